// ===== rtl/bctu_pkg.sv =====
package bctu_pkg;

  // Input word: count to format and part limit
  typedef struct packed {
    logic [63:0] count;
    logic [7:0]  max_parts;
  } in_word_t;

  // Output word: one character of text
  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } out_word_t;

  // Sequencer states
  typedef enum logic [3:0] {
    StIdle,
    StPick,
    StPlus,
    StStart,
    StConv,
    StSkip,
    StDigit,
    StLetter,
    StZero
  } state_e;

  // Unit parts, tried in this order
  typedef enum logic [1:0] {
    StageG,
    StageM,
    StageK,
    StageRem
  } stage_e;

  localparam logic [2:0] MaxParts  = 3'd4;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharG     = 8'h47;
  localparam logic [7:0] CharM     = 8'h4d;
  localparam logic [7:0] CharK     = 8'h6b;
  localparam logic [7:0] CharPlus  = 8'h2b;

endpackage

// ===== rtl/bctu_dabble.sv =====
// Shift-and-add-3 binary to BCD converter, one input bit per cycle.
module bctu_dabble #(
  parameter int unsigned ValW   = 34,
  parameter int unsigned NumDig = 11
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [ValW-1:0]       value_i,
  output logic                  done_o,
  output logic [4*NumDig-1:0]   bcd_o
);

  localparam int unsigned CntW = $clog2(ValW + 1);

  logic                running_q;
  logic [CntW-1:0]     cnt_q;
  logic [ValW-1:0]     shift_q;
  logic [4*NumDig-1:0] bcd_q;
  logic [4*NumDig-1:0] adj;

  // Add 3 to every digit of 5 or more before the shift
  always_comb begin
    logic [3:0] dig;
    dig = 4'd0;
    for (int i = 0; i < NumDig; i++) begin
      dig = bcd_q[4*i +: 4];
      adj[4*i +: 4] = (dig >= 4'd5) ? dig + 4'd3 : dig;
    end
  end

  // Track the bit count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      cnt_q     <= '0;
    end else if (start_i) begin
      running_q <= 1'b1;
      cnt_q     <= CntW'(ValW);
    end else if (running_q) begin
      if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
      end else begin
        running_q <= 1'b0;
      end
    end
  end

  // Shift one binary bit into the BCD digits
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      shift_q <= value_i;
      bcd_q   <= '0;
    end else if (running_q && cnt_q != '0) begin
      shift_q <= shift_q << 1;
      bcd_q   <= {adj[4*NumDig-2:0], shift_q[ValW-1]};
    end
  end

  assign done_o = running_q && (cnt_q == '0);
  assign bcd_o  = bcd_q;

endmodule

// ===== rtl/bctu_out_reg.sv =====
// Output register: holds one word until the sink takes it.
module bctu_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  bctu_pkg::out_word_t word_i,
  output logic                free_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bctu_pkg::out_word_t out_word_o
);

  logic                valid_q;
  bctu_pkg::out_word_t word_q;

  assign free_o = !valid_q || out_ready_i;

  // Load on push, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (push_i && free_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && free_o) begin
      word_q <= word_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

endmodule

// ===== rtl/byte_count_to_unit_text.sv =====
// ValW = max(COUNT_BITS - 30, 10) bits, NumDig BCD digits (34 and 11 at the default).
// Each part runs the one bit-serial BCD unit, skips leading zeros one per cycle, then
// sends one digit per cycle while the output register is free; a join mark goes before
// every part after the first and a unit letter after every part but the remainder.
// Throughput: one word at a time; a new word is taken only in idle, once the last
// character has been pushed. Reset (rst_ni low, async) clears the control state.
module byte_count_to_unit_text #(
  parameter int unsigned COUNT_BITS = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bctu_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bctu_pkg::out_word_t out_word_o
);

  localparam int unsigned ValW   = (COUNT_BITS > 40) ? COUNT_BITS - 30 : 10;
  localparam int unsigned NumW   = ValW + 30;
  localparam int unsigned NumDig = (ValW * 77) / 256 + 1;
  localparam int unsigned IdxW   = $clog2(NumDig);

  bctu_pkg::state_e    state_q, state_d;
  bctu_pkg::stage_e    stage_q;
  logic [2:0]          parts_q;
  logic                joined_q;
  logic [IdxW-1:0]     idx_q;
  logic [COUNT_BITS-1:0] num_q;
  logic [ValW-1:0]     val_q;

  logic [NumW-1:0]     num_ext;
  logic [ValW-1:0]     quot;
  logic                take;
  logic                accept;
  logic                conv_start;
  logic                conv_done;
  logic [4*NumDig-1:0] bcd;
  logic [3:0]          digit;
  logic                lead_zero;
  logic                emit;
  bctu_pkg::out_word_t emit_word;
  logic                out_free;

  assign accept  = in_valid_i && in_ready_o;
  assign num_ext = NumW'(num_q);

  // Select the quotient of the current part
  always_comb begin
    case (stage_q)
      bctu_pkg::StageG: quot = num_ext[NumW-1:30];
      bctu_pkg::StageM: quot = ValW'(num_ext[29:20]);
      bctu_pkg::StageK: quot = ValW'(num_ext[19:10]);
      default:          quot = ValW'(num_ext[9:0]);
    endcase
  end

  assign take = (parts_q != 3'd0) &&
                ((stage_q == bctu_pkg::StageRem) || (quot != '0));

  assign digit     = bcd[4*idx_q +: 4];
  assign lead_zero = (digit == 4'd0) && (idx_q != '0);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bctu_pkg::StIdle: begin
        if (in_valid_i) state_d = bctu_pkg::StPick;
      end
      bctu_pkg::StPick: begin
        if (take) begin
          state_d = joined_q ? bctu_pkg::StPlus : bctu_pkg::StStart;
        end else if (stage_q == bctu_pkg::StageRem) begin
          state_d = joined_q ? bctu_pkg::StIdle : bctu_pkg::StZero;
        end
      end
      bctu_pkg::StPlus: begin
        if (out_free) state_d = bctu_pkg::StStart;
      end
      bctu_pkg::StStart: state_d = bctu_pkg::StConv;
      bctu_pkg::StConv: begin
        if (conv_done) state_d = bctu_pkg::StSkip;
      end
      bctu_pkg::StSkip: begin
        if (!lead_zero) state_d = bctu_pkg::StDigit;
      end
      bctu_pkg::StDigit: begin
        if (out_free && idx_q == '0) begin
          state_d = (stage_q == bctu_pkg::StageRem) ? bctu_pkg::StIdle
                                                    : bctu_pkg::StLetter;
        end
      end
      bctu_pkg::StLetter: begin
        if (out_free) state_d = (parts_q == 3'd1) ? bctu_pkg::StIdle : bctu_pkg::StPick;
      end
      bctu_pkg::StZero: begin
        if (out_free) state_d = bctu_pkg::StIdle;
      end
      default: state_d = bctu_pkg::StIdle;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_ready_o = 1'b0;
    conv_start = 1'b0;
    emit       = 1'b0;
    emit_word  = '{character: bctu_pkg::CharZero, last: 1'b0};
    case (state_q)
      bctu_pkg::StIdle:  in_ready_o = 1'b1;
      bctu_pkg::StStart: conv_start = 1'b1;
      bctu_pkg::StPlus: begin
        emit                = 1'b1;
        emit_word.character = bctu_pkg::CharPlus;
      end
      bctu_pkg::StDigit: begin
        emit                = 1'b1;
        emit_word.character = bctu_pkg::CharZero | {4'd0, digit};
        emit_word.last      = (stage_q == bctu_pkg::StageRem) && (idx_q == '0);
      end
      bctu_pkg::StLetter: begin
        emit = 1'b1;
        case (stage_q)
          bctu_pkg::StageG: emit_word.character = bctu_pkg::CharG;
          bctu_pkg::StageM: emit_word.character = bctu_pkg::CharM;
          default:          emit_word.character = bctu_pkg::CharK;
        endcase
        emit_word.last = (parts_q == 3'd1);
      end
      bctu_pkg::StZero: begin
        emit           = 1'b1;
        emit_word.last = 1'b1;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= bctu_pkg::StIdle;
      stage_q  <= bctu_pkg::StageG;
      parts_q  <= 3'd0;
      joined_q <= 1'b0;
      idx_q    <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        bctu_pkg::StIdle: begin
          if (accept) begin
            stage_q  <= bctu_pkg::StageG;
            joined_q <= 1'b0;
            parts_q  <= (in_word_i.max_parts > 8'(bctu_pkg::MaxParts))
                        ? bctu_pkg::MaxParts : in_word_i.max_parts[2:0];
          end
        end
        bctu_pkg::StPick: begin
          if (!take && stage_q != bctu_pkg::StageRem) begin
            stage_q <= bctu_pkg::stage_e'(stage_q + 2'd1);
          end
        end
        bctu_pkg::StStart: idx_q <= IdxW'(NumDig - 1);
        bctu_pkg::StSkip: begin
          if (lead_zero) idx_q <= idx_q - 1'b1;
        end
        bctu_pkg::StDigit: begin
          if (out_free && idx_q != '0) idx_q <= idx_q - 1'b1;
        end
        bctu_pkg::StLetter: begin
          if (out_free) begin
            parts_q  <= parts_q - 3'd1;
            joined_q <= 1'b1;
            stage_q  <= bctu_pkg::stage_e'(stage_q + 2'd1);
          end
        end
        default: ;
      endcase
    end
  end

  // Hold the count and the value under conversion
  always_ff @(posedge clk_i) begin
    if (accept) begin
      num_q <= in_word_i.count[COUNT_BITS-1:0];
    end
    if (state_q == bctu_pkg::StPick && take) begin
      val_q <= quot;
    end
  end

  bctu_dabble #(
    .ValW   (ValW),
    .NumDig (NumDig)
  ) u_dabble (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (conv_start),
    .value_i (val_q),
    .done_o  (conv_done),
    .bcd_o   (bcd)
  );

  bctu_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (emit),
    .word_i      (emit_word),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule

// ===== rtl/bctu_checker.sv =====
// Port-level checks on the formatter.
module bctu_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input bctu_pkg::out_word_t out_word_o
);

  // Busy right after a word is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("ready stayed high after a word was taken");

  // While idle, only the final character may still wait
  a_idle_holds_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ready_o && out_valid_o) |-> out_word_o.last)
    else $error("idle with a non-final character pending");

  // Only digits, unit letters and the join mark appear
  a_char_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      ((out_word_o.character >= bctu_pkg::CharZero &&
        out_word_o.character <= bctu_pkg::CharNine) ||
       out_word_o.character == bctu_pkg::CharG ||
       out_word_o.character == bctu_pkg::CharM ||
       out_word_o.character == bctu_pkg::CharK ||
       out_word_o.character == bctu_pkg::CharPlus))
    else $error("unexpected character");

  // Stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_word_o)))
    else $error("output word changed while stalled");

endmodule

bind byte_count_to_unit_text bctu_checker u_bctu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_word_o  (out_word_o)
);
